FILE: sv/msdc_pkg.sv
// msdc_pkg: shared constants and types for the match sort/dedup block.
// No dependencies; used by msdc_store, msdc_cmp and match_sort_dedup_cap_top.
package msdc_pkg;

  localparam int unsigned DEPTH = 64;                  // entries in the match store
  localparam int unsigned AW    = $clog2(DEPTH);       // store address width
  localparam int unsigned CW    = $clog2(DEPTH + 1);   // count width, holds DEPTH itself
  localparam int unsigned MAXW  = 16;                  // max_matches register width

  // Sort key; field order gives contig, then position, then strand priority
  typedef struct packed {
    logic [31:0] contig;
    logic [31:0] position;
    logic [7:0]  strand;
  } key_t;

  localparam int unsigned KW = $bits(key_t);

  // Comparator result: a < b, a > b
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

FILE: sv/msdc_store.sv
// msdc_store: match store, one write port and one registered read port.
// Depends on msdc_pkg.
module msdc_store (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [msdc_pkg::AW-1:0] wr_addr,
  input  msdc_pkg::key_t       wr_data,
  input  logic                 rd_en,
  input  logic [msdc_pkg::AW-1:0] rd_addr,
  output msdc_pkg::key_t       rd_data
);

  msdc_pkg::key_t mem [msdc_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/msdc_cmp.sv
// msdc_cmp: shared unsigned key comparator.
// Depends on msdc_pkg.
module msdc_cmp (
  input  msdc_pkg::key_t     a,
  input  msdc_pkg::key_t     b,
  output msdc_pkg::cmp_res_t res
);

  logic [msdc_pkg::KW-1:0] av;
  logic [msdc_pkg::KW-1:0] bv;

  assign av     = a;
  assign bv     = b;
  assign res.lt = av < bv;
  assign res.gt = av > bv;

endmodule

FILE: sv/match_sort_dedup_cap_top.sv
// match_sort_dedup_cap_top: loads one read's matches, then sorts, dedups and caps them.
// Depends on msdc_pkg, msdc_store, msdc_cmp.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per match, in_last_in on the
//   final request of a set. A request with in_entry_present low carries no match.
//   in_ready is high only while loading, so requests can be taken back to back.
//   On the last request the block picks unique matches in ascending key order by
//   repeated minimum search: each pass reads every stored entry once (read,
//   compare with previous key, compare with current best) through the single
//   comparator, then closes the pass. With u unique keys, counting takes u+1
//   passes and output u passes; a set over the limit stops after max_matches+1
//   counting passes. Overflow or empty sets answer with a single empty result
//   straight from the judge step.
//   Output channel (out_valid/out_ready): results sit in an output register;
//   a stalled receiver holds the sequencer only when a further result is ready.
//   The final result of a set may wait while the next set loads.
//   cfg_wr_en/cfg_wr_data write max_matches (reset 64); write only while idle.
//   Reset (rst_n low, synchronous) empties the store and drops pending results.
module match_sort_dedup_cap_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // input requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_entry_present,
  input  logic [31:0] in_contig,
  input  logic [31:0] in_position,
  input  logic [7:0]  in_strand,
  input  logic        in_prior_overflow,
  input  logic        in_last_in,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_has_match,
  output logic [31:0] out_contig,
  output logic [31:0] out_position,
  output logic [7:0]  out_strand,
  output logic        out_overflow,
  output logic        out_last_out
);

  localparam int unsigned AW   = msdc_pkg::AW;
  localparam int unsigned CW   = msdc_pkg::CW;
  localparam int unsigned MAXW = msdc_pkg::MAXW;

  // sequencer states
  localparam logic [2:0] S_LOAD  = 3'd0;  // taking requests
  localparam logic [2:0] S_JUDGE = 3'd1;  // set closed, decide path
  localparam logic [2:0] S_RD    = 3'd2;  // issue store read
  localparam logic [2:0] S_CPA   = 3'd3;  // compare entry against previous key
  localparam logic [2:0] S_CPB   = 3'd4;  // compare entry against current best
  localparam logic [2:0] S_PEND  = 3'd5;  // pass done: count or emit

  localparam logic PH_COUNT = 1'b0;
  localparam logic PH_EMIT  = 1'b1;

  logic [2:0]      state_r, state_nxt;
  logic            phase_r, phase_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [MAXW-1:0] max_r;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   uniq_r, uniq_nxt;
  logic [CW-1:0]   emit_r, emit_nxt;
  logic            prev_vld_r, prev_vld_nxt;
  logic            best_vld_r, best_vld_nxt;
  logic            cand_r, cand_nxt;
  msdc_pkg::key_t  prev_r, prev_nxt;
  msdc_pkg::key_t  best_r, best_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_has_r, out_has_nxt;
  msdc_pkg::key_t  out_key_r, out_key_nxt;
  logic            out_ovf_r, out_ovf_nxt;
  logic            out_last_r, out_last_nxt;

  logic            in_fire;
  logic            out_free;
  logic            wr_en;
  logic            rd_en;
  msdc_pkg::key_t  in_key;
  msdc_pkg::key_t  rd_key;
  msdc_pkg::key_t  cmp_b;
  msdc_pkg::cmp_res_t cmp_res;
  logic [CW-1:0]   idx_inc;
  logic [MAXW:0]   uniq_inc;

  assign in_ready = (state_r == S_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign in_key.contig   = in_contig;
  assign in_key.position = in_position;
  assign in_key.strand   = in_strand;

  // drop matches once the store is full
  assign wr_en = in_fire && in_entry_present && (cnt_r < CW'(msdc_pkg::DEPTH));

  msdc_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_key),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_key)
  );

  // one comparator, operand b chosen by sequencer step
  assign cmp_b = (state_r == S_CPA) ? prev_r : best_r;

  msdc_cmp u_cmp (
    .a   (rd_key),
    .b   (cmp_b),
    .res (cmp_res)
  );

  assign idx_inc  = CW'(idx_r) + CW'(1);
  assign uniq_inc = (MAXW + 1)'(uniq_r) + (MAXW + 1)'(1);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    uniq_nxt      = uniq_r;
    emit_nxt      = emit_r;
    prev_vld_nxt  = prev_vld_r;
    best_vld_nxt  = best_vld_r;
    cand_nxt      = cand_r;
    prev_nxt      = prev_r;
    best_nxt      = best_r;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_has_nxt   = out_has_r;
    out_key_nxt   = out_key_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (in_prior_overflow) begin
            ovf_nxt = 1'b1;
          end
          if (in_entry_present) begin
            if (wr_en) begin
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_last_in) begin
            state_nxt = S_JUDGE;
          end
        end
      end

      S_JUDGE: begin
        if (ovf_r || (cnt_r == '0)) begin
          // overflow or empty set: single empty result
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_has_nxt   = 1'b0;
            out_key_nxt   = '0;
            out_ovf_nxt   = ovf_r;
            out_last_nxt  = 1'b1;
            cnt_nxt       = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = S_LOAD;
          end
        end else begin
          phase_nxt    = PH_COUNT;
          uniq_nxt     = '0;
          prev_vld_nxt = 1'b0;
          best_vld_nxt = 1'b0;
          idx_nxt      = '0;
          state_nxt    = S_RD;
        end
      end

      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_CPA;
      end

      S_CPA: begin
        // entry qualifies only if strictly above the last selected key
        cand_nxt  = !prev_vld_r || cmp_res.gt;
        state_nxt = S_CPB;
      end

      S_CPB: begin
        if (cand_r && (!best_vld_r || cmp_res.lt)) begin
          best_nxt     = rd_key;
          best_vld_nxt = 1'b1;
        end
        if (idx_inc == cnt_r) begin
          state_nxt = S_PEND;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_RD;
        end
      end

      S_PEND: begin
        if (phase_r == PH_COUNT) begin
          if (!best_vld_r) begin
            // all unique keys counted and within limit: start emitting
            phase_nxt    = PH_EMIT;
            emit_nxt     = '0;
            prev_vld_nxt = 1'b0;
            idx_nxt      = '0;
            state_nxt    = S_RD;
          end else if (uniq_inc > {1'b0, max_r}) begin
            // over the limit: stop counting, empty overflow result
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_has_nxt   = 1'b0;
              out_key_nxt   = '0;
              out_ovf_nxt   = 1'b1;
              out_last_nxt  = 1'b1;
              cnt_nxt       = '0;
              ovf_nxt       = 1'b0;
              state_nxt     = S_LOAD;
            end
          end else begin
            uniq_nxt     = uniq_r + CW'(1);
            prev_nxt     = best_r;
            prev_vld_nxt = 1'b1;
            best_vld_nxt = 1'b0;
            idx_nxt      = '0;
            state_nxt    = S_RD;
          end
        end else begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_has_nxt   = 1'b1;
            out_key_nxt   = best_r;
            out_ovf_nxt   = 1'b0;
            out_last_nxt  = (emit_r + CW'(1)) == uniq_r;
            if ((emit_r + CW'(1)) == uniq_r) begin
              cnt_nxt   = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_LOAD;
            end else begin
              emit_nxt     = emit_r + CW'(1);
              prev_nxt     = best_r;
              prev_vld_nxt = 1'b1;
              best_vld_nxt = 1'b0;
              idx_nxt      = '0;
              state_nxt    = S_RD;
            end
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      phase_r     <= PH_COUNT;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      max_r       <= MAXW'(64);
      idx_r       <= '0;
      uniq_r      <= '0;
      emit_r      <= '0;
      prev_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      cand_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      uniq_r      <= uniq_nxt;
      emit_r      <= emit_nxt;
      prev_vld_r  <= prev_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      cand_r      <= cand_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    best_r     <= best_nxt;
    out_has_r  <= out_has_nxt;
    out_key_r  <= out_key_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_has_match = out_has_r;
  assign out_contig    = out_key_r.contig;
  assign out_position  = out_key_r.position;
  assign out_strand    = out_key_r.strand;
  assign out_overflow  = out_ovf_r;
  assign out_last_out  = out_last_r;

endmodule

FILE: sv/msdc_checker.sv
// msdc_checker: port-level checks for match_sort_dedup_cap_top, bound below.
// Depends on match_sort_dedup_cap_top ports only.
module msdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_has_match,
  input logic [31:0] out_contig,
  input logic [31:0] out_position,
  input logic [7:0]  out_strand,
  input logic        out_overflow,
  input logic        out_last_out
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_has_match) &&
      $stable(out_contig) && $stable(out_position) && $stable(out_strand) &&
      $stable(out_overflow) && $stable(out_last_out))
    else $error("result changed while stalled");

  // an empty result always closes its set
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_match |-> out_last_out)
    else $error("empty result not marked last");

  // overflow never comes with a match
  a_ovf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_has_match)
    else $error("overflow result carries a match");

  // empty result has zero key fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_match |->
      (out_contig == 32'd0) && (out_position == 32'd0) && (out_strand == 8'd0))
    else $error("empty result with nonzero key");

endmodule

bind match_sort_dedup_cap_top msdc_checker u_msdc_checker (.*);

FILE: test/msdc_tb_pkg.sv
`timescale 1ns / 100ps
// msdc_tb_pkg: expected-result model and result checker for match_sort_dedup_cap_top.
// Depends on msdc_pkg (key_t, DEPTH).
package msdc_tb_pkg;

  typedef struct {
    bit             has_match;
    msdc_pkg::key_t key;
    bit             overflow;
    bit             last_out;
  } match_res_t;

  class match_set_checker;
    logic [15:0]    max_matches;
    int             errors;
    msdc_pkg::key_t loaded_keys[$];      // matches of the set being loaded
    bit             overflow_seen;
    match_res_t     unique_match_q[$];   // results still owed by the block

    function new();
      max_matches   = 16'd64;
      errors        = 0;
      overflow_seen = 1'b0;
    endfunction

    function int pending();
      return unique_match_q.size();
    endfunction

    function void push_res(bit has, msdc_pkg::key_t k, bit ovf, bit last);
      match_res_t r;
      r.has_match = has;
      r.key       = k;
      r.overflow  = ovf;
      r.last_out  = last;
      unique_match_q.push_back(r);
    endfunction

    // One accepted request; on the last of a set, queue what the set yields.
    function void note_request(bit present, msdc_pkg::key_t k, bit prior_ovf, bit last);
      msdc_pkg::key_t uniq[$];
      msdc_pkg::key_t tmp;
      int             j;
      if (prior_ovf) overflow_seen = 1'b1;
      if (present) begin
        if (loaded_keys.size() < msdc_pkg::DEPTH) loaded_keys.push_back(k);
        else overflow_seen = 1'b1;
      end
      if (!last) return;
      if (overflow_seen) begin
        push_res(1'b0, '0, 1'b1, 1'b1);
      end else if (loaded_keys.size() == 0) begin
        push_res(1'b0, '0, 1'b0, 1'b1);
      end else begin
        // packed key compares as contig, then position, then strand
        for (int i = 1; i < loaded_keys.size(); i++) begin
          tmp = loaded_keys[i];
          j = i;
          while (j > 0 && loaded_keys[j-1] > tmp) begin
            loaded_keys[j] = loaded_keys[j-1];
            j--;
          end
          loaded_keys[j] = tmp;
        end
        foreach (loaded_keys[i])
          if (uniq.size() == 0 || uniq[$] != loaded_keys[i]) uniq.push_back(loaded_keys[i]);
        if (uniq.size() > max_matches) begin
          push_res(1'b0, '0, 1'b1, 1'b1);
        end else begin
          foreach (uniq[i]) push_res(1'b1, uniq[i], 1'b0, i == uniq.size() - 1);
        end
      end
      loaded_keys.delete();
      overflow_seen = 1'b0;
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(bit has, msdc_pkg::key_t k, bit ovf, bit last);
      match_res_t want;
      if (unique_match_q.size() == 0) begin
        errors++;
        $display("%0t  unexpected result: expected none, actual has=%0b key=%h ovf=%0b last=%0b",
                 $time, has, k, ovf, last);
        return;
      end
      want = unique_match_q.pop_front();
      cmp_field("has_match", 32'(want.has_match), 32'(has));
      cmp_field("contig", want.key.contig, k.contig);
      cmp_field("position", want.key.position, k.position);
      cmp_field("strand", 32'(want.key.strand), 32'(k.strand));
      cmp_field("overflow", 32'(want.overflow), 32'(ovf));
      cmp_field("last_out", 32'(want.last_out), 32'(last));
    endfunction
  endclass

endpackage

FILE: test/match_sort_dedup_cap_top_tb.sv
`timescale 1ns / 100ps
// match_sort_dedup_cap_top_tb: directed and random regression of match_sort_dedup_cap_top.
// Depends on msdc_pkg, msdc_tb_pkg and the block's RTL.
module match_sort_dedup_cap_top_tb;

  localparam int N_REQUESTS = 310;   // stimulus stops after about this many requests
  localparam int LONG_HOLD  = 500;   // receiver back-pressure burst, in cycles
  localparam int SETTLE     = 16;    // quiet cycles before a register write and at the end

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_entry_present;
  logic [31:0] in_contig;
  logic [31:0] in_position;
  logic [7:0]  in_strand;
  logic        in_prior_overflow;
  logic        in_last_in;
  logic        out_valid;
  logic        out_ready;
  logic        out_has_match;
  logic [31:0] out_contig;
  logic [31:0] out_position;
  logic [7:0]  out_strand;
  logic        out_overflow;
  logic        out_last_out;

  msdc_tb_pkg::match_set_checker set_chk = new();

  int n_sent;    // accepted requests so far
  bit tx_calm;   // sender runs back to back for the current set
  int tx_gap;    // idle cycles before the next request

  match_sort_dedup_cap_top u_dut (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic msdc_pkg::key_t mkkey(logic [31:0] c, logic [31:0] p, logic [7:0] s);
    return {c, p, s};
  endfunction

  // Biased toward the ends of the range and tiny values so keys collide often.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic msdc_pkg::key_t rand_key();
    msdc_pkg::key_t k;
    k.contig   = pick_word();
    k.position = pick_word();
    case ($urandom_range(0, 3))
      0:       k.strand = "+";
      1:       k.strand = "-";
      2:       k.strand = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: k.strand = 8'($urandom);
    endcase
    return k;
  endfunction

  // Offer one request and hold it until accepted. Valid is dropped right after
  // acceptance only when a gap follows, so it never toggles within one step.
  task automatic send_req(bit present, msdc_pkg::key_t k, bit pov, bit last);
    if (tx_gap > 0) repeat (tx_gap) @(posedge clk);
    in_valid          <= 1'b1;
    in_entry_present  <= present;
    in_contig         <= k.contig;
    in_position       <= k.position;
    in_strand         <= k.strand;
    in_prior_overflow <= pov;
    in_last_in        <= last;
    do @(posedge clk); while (!in_ready);
    set_chk.note_request(present, k, pov, last);
    n_sent++;
    tx_gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (tx_gap > 0) in_valid <= 1'b0;
  endtask

  // Sender pause: wait until every owed result is out and the block has gone quiet.
  task automatic drain();
    if (tx_gap == 0) in_valid <= 1'b0;
    tx_gap = 0;
    while (set_chk.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    set_chk.max_matches = v;
  endtask

  // DEPTH distinct matches (strand alone keeps them apart) in scrambled order:
  // the biggest result burst the block can give.
  task automatic full_unique_set();
    tx_calm = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < msdc_pkg::DEPTH; i++)
      send_req(1'b1, mkkey($urandom_range(0, 1), $urandom, 8'(i)), 1'b0,
               i == msdc_pkg::DEPTH - 1);
  endtask

  // One random set. Mix: mostly well-formed sets with colliding keys, some with
  // a prior overflow flag, bare (empty) sets, raw noise, and a few that fill or
  // spill the store using only a handful of distinct keys.
  task automatic random_set();
    int             kind;
    int             n;
    int             pov_at;
    bit             noise;
    bit             present;
    msdc_pkg::key_t seen[$];
    msdc_pkg::key_t k;
    kind    = $urandom_range(0, 99);
    tx_calm = ($urandom_range(0, 3) == 0);
    noise   = (kind >= 82 && kind < 97);
    if (kind >= 97) n = $urandom_range(msdc_pkg::DEPTH - 2, msdc_pkg::DEPTH + 2);
    else if (noise) n = $urandom_range(1, 4);
    else n = $urandom_range(1, 8);
    pov_at = (kind >= 62 && kind < 74) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (noise) begin
        k = {$urandom, $urandom, 8'($urandom)};
        send_req($urandom_range(0, 1) == 1, k, $urandom_range(0, 7) == 0, i == n - 1);
      end else begin
        present = (kind >= 74 && kind < 82) ? 1'b0 :
                  (kind >= 97 || $urandom_range(0, 7) != 0);
        if (seen.size() > 0 && ((kind >= 97 && seen.size() >= 3) || $urandom_range(0, 2) == 0))
          k = seen[$urandom_range(0, seen.size() - 1)];
        else
          k = rand_key();
        if (present) seen.push_back(k);
        send_req(present, k, i == pov_at, i == n - 1);
      end
    end
  endtask

  // Result side: checks every accepted result, stalls randomly after each result
  // with calm stretches, and now and then holds off for a long burst while the
  // set is still streaming, so the block backs up into its input.
  initial begin : result_side
    int             hold;
    int             n_results;
    int             next_hold_at;
    bit             rx_calm;
    msdc_pkg::key_t got;
    hold         = 0;
    n_results    = 0;
    next_hold_at = 40;
    rx_calm      = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = {out_contig, out_position, out_strand};
        set_chk.check_result(out_has_match, got, out_overflow, out_last_out);
        n_results++;
        if (n_results >= next_hold_at && !out_last_out) begin
          hold         = LONG_HOLD;
          next_hold_at = n_results + 150;
        end else begin
          if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
          hold = rx_calm ? 0 : $urandom_range(0, 5);
        end
      end else if (hold > 0) begin
        hold--;
      end
      out_ready <= (hold == 0);
    end
  end

  // Request side: reset, directed sets, then random phases under several limits.
  initial begin : request_side
    msdc_pkg::key_t junk;
    int             phase;
    n_sent  = 0;
    tx_calm = 1'b0;
    tx_gap  = 0;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_valid          <= 1'b0;
    in_entry_present  <= 1'b0;
    in_contig         <= '0;
    in_position       <= '0;
    in_strand         <= '0;
    in_prior_overflow <= 1'b0;
    in_last_in        <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, reset limit of 64 ----
    junk = rand_key();
    // empty set: one bare last request
    send_req(1'b0, junk, 1'b0, 1'b1);
    // single match at the top, then the bottom, of every field
    send_req(1'b1, mkkey('1, '1, '1), 1'b0, 1'b1);
    send_req(1'b1, '0, 1'b0, 1'b1);
    // ordering on each key field, one exact duplicate, a bare request mid-set
    send_req(1'b1, mkkey(5, 10, "-"), 1'b0, 1'b0);
    send_req(1'b1, mkkey(5, 10, "+"), 1'b0, 1'b0);
    send_req(1'b1, mkkey(5, 10, "-"), 1'b0, 1'b0);
    send_req(1'b0, junk, 1'b0, 1'b0);
    send_req(1'b1, mkkey(5, 9, 8'hFF), 1'b0, 1'b0);
    send_req(1'b1, mkkey(4, 32'hFFFF_FFFF, 8'd0), 1'b0, 1'b1);
    // prior overflow on a bare request, then on the last request
    send_req(1'b0, junk, 1'b1, 1'b0);
    send_req(1'b1, mkkey(1, 1, 8'd1), 1'b0, 1'b1);
    send_req(1'b1, mkkey(2, 2, 8'd2), 1'b0, 1'b0);
    send_req(1'b1, mkkey(3, 3, 8'd3), 1'b1, 1'b1);
    // nonempty set closed by a bare last request
    send_req(1'b1, mkkey(7, 7, 8'd7), 1'b0, 1'b0);
    send_req(1'b0, junk, 1'b0, 1'b1);

    // limit of two: three unique overflow, two unique after dedup pass
    set_limit(16'd2);
    send_req(1'b1, mkkey(9, 1, "+"), 1'b0, 1'b0);
    send_req(1'b1, mkkey(9, 1, "-"), 1'b0, 1'b0);
    send_req(1'b1, mkkey(8, 1, "+"), 1'b0, 1'b1);
    send_req(1'b1, mkkey(9, 1, "+"), 1'b0, 1'b0);
    send_req(1'b1, mkkey(9, 1, "+"), 1'b0, 1'b0);
    send_req(1'b1, mkkey(0, 0, 8'd0), 1'b0, 1'b1);

    // limit of zero: any match overflows, an empty set still does not
    set_limit(16'd0);
    send_req(1'b1, mkkey(6, 6, 8'd6), 1'b0, 1'b1);
    send_req(1'b0, junk, 1'b0, 1'b1);

    // ---- random phases; each starts from an idle block with a new limit ----
    phase = 0;
    while (n_sent < N_REQUESTS || phase <= 3) begin
      case (phase % 6)
        0:       set_limit(16'hFFFF);
        1:       set_limit(16'd0);
        2:       set_limit(16'($urandom_range(1, 4)));
        3:       set_limit(16'd64);
        4:       set_limit(16'($urandom_range(5, 70)));
        default: set_limit(16'($urandom_range(0, 65535)));
      endcase
      // limit equal to the store size with a full store of unique matches
      if (phase == 3) full_unique_set();
      repeat ($urandom_range(5, 10)) if (n_sent < N_REQUESTS) random_set();
      phase++;
    end

    drain();
    if (set_chk.errors == 0 && set_chk.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/msdc_pkg.sv
sv/msdc_store.sv
sv/msdc_cmp.sv
sv/match_sort_dedup_cap_top.sv
sv/msdc_checker.sv
test/msdc_tb_pkg.sv
test/match_sort_dedup_cap_top_tb.sv
